### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside of reset.
`define SLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside of reset.
`define SLD_ASSERT_NEVER(lbl, cond, msg) \
  `SLD_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

  localparam int unsigned HashBytes = 8;
  localparam int unsigned TimeBytes = 8;
  localparam int unsigned LenBytes  = 4;
  localparam int unsigned MinLen    = TimeBytes + HashBytes;

  localparam logic [7:0] SyncA = 8'hE2;
  localparam logic [7:0] SyncB = 8'h98;
  localparam logic [7:0] SyncC = 8'hA2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ONE  = 3'd1,
    PH_TWO  = 3'd2,
    PH_LEN  = 3'd3,
    PH_TIME = 3'd4,
    PH_HASH = 3'd5,
    PH_PAY  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SHORT   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] time_stamp;
    logic [63:0] type_hash;
    logic [31:0] payload_count;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

### hw/rtl/sld_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sld_core import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  cnt_inc;
  logic [31:0] len_q, len_d;
  logic [63:0] time_q, time_d;
  logic [63:0] hash_q, hash_d;
  logic [31:0] left_q, left_d;
  logic [31:0] pay_cnt;

  assign cnt_inc = {1'b0, cnt_q} + 4'd1;
  assign pay_cnt = len_q - 32'(MinLen);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    time_d      = time_q;
    hash_d      = hash_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_LEN: begin
        len_d[{cnt_q[1:0], 3'b000} +: 8] = len_q[{cnt_q[1:0], 3'b000} +: 8] | byte_i;
        cnt_d = cnt_inc[2:0];
        if (cnt_inc >= 4'(LenBytes)) begin
          cnt_d = '0;
          if (len_d < 32'(MinLen)) begin
            phase_d     = PH_HUNT;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_SHORT;
            res_o.last  = 1'b1;
          end else begin
            phase_d = PH_TIME;
          end
        end
      end
      PH_TIME: begin
        time_d[{cnt_q, 3'b000} +: 8] = time_q[{cnt_q, 3'b000} +: 8] | byte_i;
        cnt_d = cnt_inc[2:0];
        if (cnt_inc >= 4'(TimeBytes)) begin
          cnt_d   = '0;
          phase_d = PH_HASH;
        end
      end
      PH_HASH: begin
        hash_d[{cnt_q, 3'b000} +: 8] = hash_q[{cnt_q, 3'b000} +: 8] | byte_i;
        cnt_d = cnt_inc[2:0];
        if (cnt_inc >= 4'(HashBytes)) begin
          cnt_d               = '0;
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_HEADER;
          res_o.time_stamp    = time_q;
          res_o.type_hash     = hash_d;
          res_o.payload_count = pay_cnt;
          res_o.last          = (pay_cnt == '0);
          if (pay_cnt == '0) begin
            phase_d = PH_HUNT;
          end else begin
            left_d  = pay_cnt;
            phase_d = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = byte_i;
        res_o.last         = (left_q <= 32'd1);
        if (left_q <= 32'd1) begin
          left_d  = '0;
          phase_d = PH_HUNT;
        end else begin
          left_d = left_q - 32'd1;
        end
      end
      default: begin
        // An E2 always restarts the sync match, also in the middle of one.
        if (byte_i == SyncA) begin
          phase_d = PH_ONE;
        end else if (byte_i == SyncB && phase_q == PH_ONE) begin
          phase_d = PH_TWO;
        end else if (byte_i == SyncC && phase_q == PH_TWO) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
          len_d   = '0;
          time_d  = '0;
          hash_d  = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      len_q   <= '0;
      time_q  <= '0;
      hash_q  <= '0;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      time_q  <= time_d;
      hash_q  <= hash_d;
      left_q  <= left_d;
    end
  end

  `SLD_ASSERT(a_len_cnt_range, (phase_q == PH_LEN) |-> (cnt_q < 3'(LenBytes)), "length count")
  `SLD_ASSERT_NEVER(a_pay_left_zero, (phase_q == PH_PAY) && (left_q == '0), "empty payload")
  `SLD_ASSERT(a_res_phase, res_valid_o |-> (phase_q > PH_TWO), "result while hunting")

endmodule

### hw/rtl/sync_length_deframer_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sync-word deframer for a byte stream: one byte is accepted per clock cycle while
// in_ready_o is high; a request that completes a result registers it into the output
// entry, or the skid entry while the output stalls. The core updates the framing state
// on each accepted byte. Results pass through a two-entry output buffer, so one stalled
// result does not stop the input; a second one drops in_ready_o until the output drains.
module sync_length_deframer_unit import sld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [63:0] time_stamp_o,
  output logic [63:0] type_hash_o,
  output logic [31:0] payload_count_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);

  logic    step;
  logic    res_valid;
  result_t res;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;
  assign step       = in_valid_i && in_ready_o;

  sld_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (stream_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = step && res_valid;
        out_d       = res;
      end
    end else if (step && res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign time_stamp_o    = out_q.time_stamp;
  assign type_hash_o     = out_q.type_hash;
  assign payload_count_o = out_q.payload_count;
  assign payload_byte_o  = out_q.payload_byte;
  assign last_o          = out_q.last;

  `SLD_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `SLD_ASSERT(a_short_is_last, (out_valid_q && out_q.kind == KIND_SHORT) |-> out_q.last, "short")
  `SLD_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> out_valid_q, "output request dropped")

endmodule
